### rtl/eaf_pkg.sv
package eaf_pkg;

  localparam int InW  = 32;
  localparam int OutW = 48;

  localparam logic [1:0] RegKe     = 2'd0;
  localparam logic [1:0] RegLaw    = 2'd1;
  localparam logic [1:0] RegNewton = 2'd2;

  localparam logic LawLinear = 1'b0;
  localparam logic LawInvSq  = 1'b1;

  typedef struct packed {
    logic [31:0] ke;
    logic        law;
    logic        newton;
  } cfg_t;

  // per-item geometry after the front end
  typedef struct packed {
    logic [31:0] ad_x;
    logic [31:0] ad_y;
    logic [31:0] ad_z;
    logic [2:0]  neg;
    logic [64:0] rsq;
    logic [32:0] radsum;
    logic [32:0] ms;
    logic        partner;
  } geo_t;

endpackage

### rtl/eaf_divider.sv
// Restoring divider, one quotient bit per stage, fully pipelined.
module eaf_divider
  import eaf_pkg::*;
#(
  parameter int NumW = 128,
  parameter int DenW = 64,
  parameter int TagW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [NumW-1:0] in_num,
  input  logic [DenW-1:0] in_den,
  input  logic [TagW-1:0] in_tag,
  output logic            out_valid,
  output logic [NumW-1:0] out_quo,
  output logic [TagW-1:0] out_tag
);

  logic [NumW:0]   vld_r;
  logic [NumW-1:0] num_r [NumW+1];
  logic [DenW:0]   rem_r [NumW+1];
  logic [DenW-1:0] den_r [NumW+1];
  logic [TagW-1:0] tag_r [NumW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NumW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    num_r[0] <= in_num;
    rem_r[0] <= '0;
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] shl;
    logic [DenW+1:0] diff;
    always_comb begin
      shl  = {rem_r[s], num_r[s][NumW-1]};
      diff = shl - {2'b00, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!diff[DenW+1]) begin
        rem_r[s+1] <= diff[DenW:0];
        num_r[s+1] <= {num_r[s][NumW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= shl[DenW:0];
        num_r[s+1] <= {num_r[s][NumW-2:0], 1'b0};
      end
      den_r[s+1] <= den_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_valid = vld_r[NumW];
  assign out_quo   = num_r[NumW];
  assign out_tag   = tag_r[NumW];

endmodule

### rtl/eaf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module eaf_sqrt
  import eaf_pkg::*;
#(
  parameter int RootW = 33,
  parameter int TagW  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2*RootW-1:0] in_val,
  input  logic [TagW-1:0]   in_tag,
  output logic              out_valid,
  output logic [RootW-1:0]  out_root,
  output logic [TagW-1:0]   out_tag
);

  localparam int VW = 2 * RootW;

  logic [RootW:0]  vld_r;
  logic [VW-1:0]   val_r  [RootW+1];
  logic [RootW+1:0] rem_r [RootW+1];
  logic [RootW-1:0] root_r [RootW+1];
  logic [TagW-1:0] tag_r  [RootW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RootW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    val_r[0]  <= in_val;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RootW+1:0] cur;
    logic [RootW+1:0] trial;
    logic [RootW+2:0] diff;
    always_comb begin
      cur   = {rem_r[s][RootW-1:0], val_r[s][VW-1:VW-2]};
      trial = {root_r[s], 2'b01};
      diff  = {1'b0, cur} - {1'b0, trial};
    end
    always_ff @(posedge clk) begin
      if (!diff[RootW+2]) begin
        rem_r[s+1]  <= diff[RootW+1:0];
        root_r[s+1] <= {root_r[s][RootW-2:0], 1'b1};
      end else begin
        rem_r[s+1]  <= cur;
        root_r[s+1] <= {root_r[s][RootW-2:0], 1'b0};
      end
      val_r[s+1] <= {val_r[s][VW-3:0], 2'b00};
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_valid = vld_r[RootW];
  assign out_root  = root_r[RootW];
  assign out_tag   = tag_r[RootW];

endmodule

### rtl/eaf_delay.sv
// Fixed-latency register line for side payload.
module eaf_delay #(
  parameter int W     = 8,
  parameter int Depth = 4
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line_r [Depth];

  always_ff @(posedge clk) begin
    line_r[0] <= din;
    for (int i = 1; i < Depth; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[Depth-1];

endmodule

### rtl/eps_adhesion_pair_force_top.sv
// Adhesion force of one neighbor pair per clock. A transaction is taken on
// any cycle with start high (busy is always low); the result appears on the
// out_ ports with out_valid high for one cycle, one result per item, in order.
// The pipeline is a chain of stages: three front-end stages (magnitudes,
// squares, range checks), a pipelined divider for the inverse square
// quotient (the pipelined square root runs beside it), a factor select stage,
// the multiply stages F, G, H and I, one pipelined divider per component for
// the scaling and the output register. Items can follow back to back. The
// receiver cannot stall the block.
// Configuration writes apply to items accepted after them.
module eps_adhesion_pair_force_top
  import eaf_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_delta_x,
  input  logic signed [31:0] in_delta_y,
  input  logic signed [31:0] in_delta_z,
  input  logic [31:0] in_radius_i,
  input  logic [31:0] in_radius_j,
  input  logic [31:0] in_plain_mass_i,
  input  logic [31:0] in_outer_mass_i,
  input  logic        in_is_eps_i,
  input  logic [31:0] in_plain_mass_j,
  input  logic [31:0] in_outer_mass_j,
  input  logic        in_is_eps_j,
  input  logic        in_partner_local,
  output logic        out_valid,
  output logic signed [47:0] out_force_x,
  output logic signed [47:0] out_force_y,
  output logic signed [47:0] out_force_z,
  output logic        out_apply_to_partner,
  output logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int F2 = 2 * FRACTION_BITS;

  // ---------------- configuration ----------------
  cfg_t cfg_r;
  logic [1:0] cfg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ke     <= 32'd65536;
      cfg_r.law    <= LawLinear;
      cfg_r.newton <= 1'b1;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (cfg_idx)
        RegKe:     cfg_r.ke     <= pwdata;
        RegLaw:    cfg_r.law    <= pwdata[0];
        RegNewton: cfg_r.newton <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegKe:     prdata = cfg_r.ke;
      RegLaw:    prdata = {31'd0, cfg_r.law};
      RegNewton: prdata = {31'd0, cfg_r.newton};
      default:   prdata = '0;
    endcase
  end

  // ---------------- stage A: magnitudes, sums ----------------
  logic        a_vld_r;
  logic [31:0] a_ad_r [3];
  logic [2:0]  a_neg_r;
  logic [32:0] a_radsum_r, a_ms_r;
  logic [31:0] a_ke_r;
  logic        a_law_r, a_apply_r;
  logic [31:0] din [3];

  assign din[0] = in_delta_x;
  assign din[1] = in_delta_y;
  assign din[2] = in_delta_z;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_neg_r[k] <= din[k][31];
      a_ad_r[k]  <= din[k][31] ? (32'd0 - din[k]) : din[k];
    end
    a_radsum_r <= {1'b0, in_radius_i} + {1'b0, in_radius_j};
    a_ms_r <= {1'b0, in_is_eps_i ? in_plain_mass_i : in_outer_mass_i}
            + {1'b0, in_is_eps_j ? in_plain_mass_j : in_outer_mass_j};
    a_ke_r    <= cfg_r.ke;
    a_law_r   <= cfg_r.law;
    a_apply_r <= cfg_r.newton || in_partner_local;
  end

  // ---------------- stage B: squares, ke products ----------------
  logic        b_vld_r;
  logic [63:0] b_sq_r [3];
  logic [65:0] b_rs2_r;
  logic [64:0] b_rke_r;
  logic [64:0] b_mske_r;
  logic [31:0] b_ad_r [3];
  logic [2:0]  b_neg_r;
  logic [32:0] b_radsum_r;
  logic        b_law_r, b_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      b_sq_r[k] <= 64'(a_ad_r[k]) * 64'(a_ad_r[k]);
    end
    b_rs2_r    <= 66'(a_radsum_r) * 66'(a_radsum_r);
    b_rke_r    <= 65'(a_radsum_r) * 65'(a_ke_r);
    b_mske_r   <= 65'(a_ms_r) * 65'(a_ke_r);
    b_ad_r     <= a_ad_r;
    b_neg_r    <= a_neg_r;
    b_radsum_r <= a_radsum_r;
    b_law_r    <= a_law_r;
    b_apply_r  <= a_apply_r;
  end

  // ---------------- stage C: rsq and range checks ----------------
  logic        c_vld_r;
  logic [65:0] c_rsq_r;
  logic        c_acts_r;
  logic [65:0] c_rs2_r;
  logic [64:0] c_mske_r;
  logic [31:0] c_ad_r [3];
  logic [2:0]  c_neg_r;
  logic [32:0] c_radsum_r;
  logic        c_law_r, c_apply_r;
  logic [65:0] rsq_sum;
  logic        above, in_lin, in_inv;

  always_comb begin
    rsq_sum = 66'(b_sq_r[0]) + 66'(b_sq_r[1]) + 66'(b_sq_r[2]);
    above   = b_rs2_r < rsq_sum;
    in_lin  = {2'b00, rsq_sum} < {b_rs2_r, 2'b00};
    in_inv  = {1'b0, rsq_sum} < {b_rke_r, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    c_rsq_r    <= rsq_sum;
    c_acts_r   <= above && ((b_law_r == LawLinear) ? in_lin : in_inv);
    c_rs2_r    <= b_rs2_r;
    c_mske_r   <= b_mske_r;
    c_ad_r     <= b_ad_r;
    c_neg_r    <= b_neg_r;
    c_radsum_r <= b_radsum_r;
    c_law_r    <= b_law_r;
    c_apply_r  <= b_apply_r;
  end

  // ---------------- square root and inverse square quotient ----------------
  // Root of rsq: rsq <= 3*2^62, so 33 result bits suffice.
  localparam int SideW = 32*3 + 3 + 33 + 65 + 1 + 1 + 1;
  logic [SideW-1:0] c_side;
  logic [SideW-1:0] d_side;
  logic              sq_vld;
  logic [32:0]       sq_root;
  logic              sq_acts;
  logic              dv_vld;
  logic [127:0]      dv_quo;
  logic              dv_acts;
  logic [32:0]       root_d;
  logic [127:0]      q_num;

  assign c_side = {c_ad_r[0], c_ad_r[1], c_ad_r[2], c_neg_r, c_radsum_r, c_mske_r,
                   c_acts_r, c_law_r, c_apply_r};
  assign q_num  = 128'(c_rs2_r) << FRACTION_BITS;

  eaf_sqrt #(.RootW(33), .TagW(1)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(c_vld_r), .in_val(c_rsq_r),
    .in_tag(c_acts_r), .out_valid(sq_vld), .out_root(sq_root), .out_tag(sq_acts)
  );

  // quotient is only used when the inverse square law acts, so rsq > 0
  eaf_divider #(.NumW(128), .DenW(66), .TagW(1)) u_qdiv (
    .clk(clk), .rst_n(rst_n), .in_valid(c_vld_r), .in_num(q_num),
    .in_den(c_rsq_r | 66'(!c_acts_r)), .in_tag(c_acts_r),
    .out_valid(dv_vld), .out_quo(dv_quo), .out_tag(dv_acts)
  );

  eaf_delay #(.W(SideW), .Depth(129)) u_side_d (
    .clk(clk), .din(c_side), .dout(d_side)
  );

  // the root leaves the square root before the quotient: delay it to meet the quotient
  eaf_delay #(.W(33), .Depth(95)) u_root_d (
    .clk(clk), .din(sq_root), .dout(root_d)
  );

  // ---------------- stage E: factor select ----------------
  logic [31:0] d_ad [3];
  logic [2:0]  d_neg;
  logic [32:0] d_radsum;
  logic [64:0] d_mske;
  logic        d_acts, d_law, d_apply;

  assign {d_ad[0], d_ad[1], d_ad[2], d_neg, d_radsum, d_mske, d_acts, d_law, d_apply}
    = d_side;

  logic        e_vld_r;
  logic [63:0] e_fac_r;
  logic [64:0] e_mske_r;
  logic [32:0] e_root_r;
  logic [31:0] e_ad_r [3];
  logic [2:0]  e_neg_r;
  logic        e_acts_r, e_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else        e_vld_r <= dv_vld;
  end

  // the model takes r - radsum and the quotient modulo 2^64
  always_ff @(posedge clk) begin
    if (d_law == LawLinear) e_fac_r <= 64'(root_d) - 64'(d_radsum);
    else                    e_fac_r <= dv_quo[63:0];
    e_mske_r  <= d_mske;
    e_root_r  <= root_d;
    e_ad_r    <= d_ad;
    e_neg_r   <= d_neg;
    e_acts_r  <= d_acts && (root_d != '0);
    e_apply_r <= d_apply;
  end

  // ---------------- stages F/G/H: mag = (mske * fac mod 2^128) >> 2F ----------
  // Split into 32-bit partial products over two stages.
  logic        f_vld_r;
  logic [64:0] f_p_r [2];
  logic [63:0] f_hi_mske_r;
  logic [63:0] f_fac_r;
  logic [32:0] f_root_r;
  logic [31:0] f_ad_r [3];
  logic [2:0]  f_neg_r;
  logic        f_acts_r, f_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else        f_vld_r <= e_vld_r;
  end

  always_ff @(posedge clk) begin
    f_p_r[0]    <= 65'(e_mske_r[31:0]) * 65'(e_fac_r[31:0]);
    f_p_r[1]    <= 65'(e_mske_r[31:0]) * 65'(e_fac_r[63:32]);
    f_hi_mske_r <= 64'(e_mske_r[64:32]);
    f_fac_r     <= e_fac_r;
    f_root_r    <= e_root_r;
    f_ad_r      <= e_ad_r;
    f_neg_r     <= e_neg_r;
    f_acts_r    <= e_acts_r;
    f_apply_r   <= e_apply_r;
  end

  logic        g_vld_r;
  logic [127:0] g_lo_r;
  logic [65:0] g_q_r [2];
  logic [32:0] g_root_r;
  logic [31:0] g_ad_r [3];
  logic [2:0]  g_neg_r;
  logic        g_acts_r, g_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else        g_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    g_lo_r   <= 128'(f_p_r[0]) + (128'(f_p_r[1]) << 32);
    g_q_r[0] <= 66'(f_hi_mske_r[32:0]) * 66'(f_fac_r[31:0]);
    g_q_r[1] <= 66'(f_hi_mske_r[32:0]) * 66'(f_fac_r[63:32]);
    g_root_r <= f_root_r;
    g_ad_r   <= f_ad_r;
    g_neg_r  <= f_neg_r;
    g_acts_r <= f_acts_r;
    g_apply_r <= f_apply_r;
  end

  logic        h_vld_r;
  logic [127:0] h_mag_r;
  logic [32:0] h_root_r;
  logic [31:0] h_ad_r [3];
  logic [2:0]  h_neg_r;
  logic        h_acts_r, h_apply_r;
  logic [127:0] prod_full;

  assign prod_full = g_lo_r + (128'(g_q_r[0]) << 32) + (128'(g_q_r[1]) << 64);

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else        h_vld_r <= g_vld_r;
  end

  always_ff @(posedge clk) begin
    h_mag_r  <= g_acts_r ? (prod_full >> F2) : '0;
    h_root_r <= g_root_r;
    h_ad_r   <= g_ad_r;
    h_neg_r  <= g_neg_r;
    h_acts_r <= g_acts_r;
    h_apply_r <= g_apply_r;
  end

  // ---------------- stages I/J: mag * |d| mod 2^128, 32-bit limbs ----------
  logic        i_vld_r;
  logic [63:0] i_pp_r [3][4];
  logic [32:0] i_root_r;
  logic [2:0]  i_neg_r, i_nz_r;
  logic        i_apply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_vld_r <= 1'b0;
    else        i_vld_r <= h_vld_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 4; m++) begin
        i_pp_r[k][m] <= 64'(h_mag_r[32*m +: 32]) * 64'(h_ad_r[k]);
      end
      i_nz_r[k] <= h_acts_r && (h_ad_r[k] != '0);
    end
    i_root_r  <= h_root_r;
    i_neg_r   <= h_neg_r;
    i_apply_r <= h_apply_r;
  end

  logic [127:0] j_num [3];
  for (genvar k = 0; k < 3; k++) begin : g_num
    assign j_num[k] = 128'(i_pp_r[k][0]) + (128'(i_pp_r[k][1]) << 32)
                    + (128'(i_pp_r[k][2]) << 64) + (128'(i_pp_r[k][3]) << 96);
  end

  localparam int TailW = 3 + 3 + 1;
  logic [2:0]   cv_vld;
  logic [127:0] cv_quo [3];
  logic [TailW-1:0] tail [3];

  for (genvar k = 0; k < 3; k++) begin : g_cdiv
    eaf_divider #(.NumW(128), .DenW(33), .TagW(TailW)) u_cdiv (
      .clk(clk), .rst_n(rst_n), .in_valid(i_vld_r), .in_num(j_num[k]),
      .in_den(i_root_r | 33'(!i_nz_r[k])),
      .in_tag({i_neg_r, i_nz_r, i_apply_r}),
      .out_valid(cv_vld[k]), .out_quo(cv_quo[k]), .out_tag(tail[k])
    );
  end

  // ---------------- output stage: sign and saturation ----------------
  logic [2:0]  t_neg, t_nz;
  logic        t_apply;
  logic [47:0] fv [3];
  logic [2:0]  fsat;

  assign {t_neg, t_nz, t_apply} = tail[0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fv[k]   = '0;
      fsat[k] = 1'b0;
      if (t_nz[k]) begin
        if (!t_neg[k]) begin
          if (cv_quo[k] > 128'h8000_0000_0000) begin
            fv[k] = 48'h8000_0000_0000;
            fsat[k] = 1'b1;
          end else begin
            fv[k] = 48'd0 - cv_quo[k][47:0];
          end
        end else begin
          if (cv_quo[k] > 128'h7FFF_FFFF_FFFF) begin
            fv[k] = 48'h7FFF_FFFF_FFFF;
            fsat[k] = 1'b1;
          end else begin
            fv[k] = cv_quo[k][47:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cv_vld[0];
  end

  always_ff @(posedge clk) begin
    out_force_x          <= fv[0];
    out_force_y          <= fv[1];
    out_force_z          <= fv[2];
    out_apply_to_partner <= t_apply;
    out_saturated        <= |fsat;
  end

  // x force sign is opposite to a positive delta, or the force is zero
  assert property (@(posedge clk) disable iff (!rst_n)
    cv_vld[0] && t_nz[0] && !t_neg[0] |=> out_force_x[47] || out_force_x == '0)
    else $error("x force sign");
  assert property (@(posedge clk) disable iff (!rst_n)
    cv_vld[0] |-> cv_vld[1] && cv_vld[2])
    else $error("component lanes out of step");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |-> $past(fsat) == 3'b000)
    else $error("saturation flag lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld |-> $past(sq_vld, 95))
    else $error("root and quotient misaligned");
  assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld |-> dv_acts == d_acts)
    else $error("quotient and side data misaligned");
  assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld |-> sq_acts == $past(c_acts_r, 34))
    else $error("root tag misaligned");

endmodule

### dv/testbench.sv
module testbench
  import eaf_pkg::*;
();

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned RandPerPhase = 230;
  localparam logic [127:0] Mask48 = 128'hFFFF_FFFF_FFFF;
  localparam logic [127:0] PosLimit = 128'h7FFF_FFFF_FFFF;
  localparam logic [127:0] NegLimit = 128'h8000_0000_0000;

  typedef struct {
    logic [31:0] dx, dy, dz;
    logic [31:0] rad_i, rad_j;
    logic [31:0] pm_i, om_i, pm_j, om_j;
    logic        eps_i, eps_j, local_j;
  } pair_t;

  typedef struct {
    logic [47:0] fx, fy, fz;
    logic        apply;
    logic        sat;
  } force_t;

  typedef struct {
    pair_t  p;
    bit     typed;
    force_t f;
  } row_t;

  logic clk, rst_n, start, busy;
  logic signed [31:0] in_delta_x, in_delta_y, in_delta_z;
  logic [31:0] in_radius_i, in_radius_j;
  logic [31:0] in_plain_mass_i, in_outer_mass_i, in_plain_mass_j, in_outer_mass_j;
  logic in_is_eps_i, in_is_eps_j, in_partner_local;
  logic out_valid, out_apply_to_partner, out_saturated;
  logic signed [47:0] out_force_x, out_force_y, out_force_z;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  // predictor copy of the register file
  logic [31:0] ke_q;
  logic        law_q, newton_q;

  force_t pending_forces[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  eps_adhesion_pair_force_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_delta_x(in_delta_x), .in_delta_y(in_delta_y), .in_delta_z(in_delta_z),
    .in_radius_i(in_radius_i), .in_radius_j(in_radius_j),
    .in_plain_mass_i(in_plain_mass_i), .in_outer_mass_i(in_outer_mass_i),
    .in_is_eps_i(in_is_eps_i),
    .in_plain_mass_j(in_plain_mass_j), .in_outer_mass_j(in_outer_mass_j),
    .in_is_eps_j(in_is_eps_j), .in_partner_local(in_partner_local),
    .out_valid(out_valid), .out_force_x(out_force_x), .out_force_y(out_force_y),
    .out_force_z(out_force_z), .out_apply_to_partner(out_apply_to_partner),
    .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic force_t pair_force(pair_t p);
    logic [127:0] ad[3];
    logic [127:0] rsq, r, radsum, ms, mi, mj, rs2, mag, q, c, rem, bitv, prod;
    bit ng[3];
    bit acts, sat;
    logic [47:0] comp[3];
    force_t f;
    logic [31:0] d[3];
    logic [31:0] dm;
    d[0] = p.dx; d[1] = p.dy; d[2] = p.dz;
    for (int k = 0; k < 3; k++) begin
      ng[k] = d[k][31];
      dm = ng[k] ? (~d[k] + 32'd1) : d[k];
      ad[k] = 128'(dm);
    end
    rsq = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
    // floor square root, digit by digit
    rem = rsq;
    r = 0;
    bitv = 128'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    radsum = 128'(p.rad_i) + 128'(p.rad_j);
    mi = 128'(p.eps_i ? p.pm_i : p.om_i);
    mj = 128'(p.eps_j ? p.pm_j : p.om_j);
    ms = mi + mj;
    rs2 = radsum * radsum;
    acts = 1'b0;
    sat = 1'b0;
    mag = 0;
    if (rs2 < rsq) begin
      if (law_q == LawLinear) begin
        if (rsq < (rs2 << 2)) begin
          acts = 1'b1;
          prod = ms * 128'(ke_q) * ((r - radsum) & 128'hFFFF_FFFF_FFFF_FFFF);
          mag = prod >> 32;
        end
      end else begin
        if (rsq < ((radsum * 128'(ke_q)) << 2)) begin
          acts = 1'b1;
          q = ((rs2 << 16) / rsq) & 128'hFFFF_FFFF_FFFF_FFFF;
          prod = ms * 128'(ke_q) * q;
          mag = prod >> 32;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      comp[k] = '0;
      if (acts && r != 0 && ad[k] != 0) begin
        c = (mag * ad[k]) / r;
        if (!ng[k]) begin
          // attraction: positive separation pulls negative
          if (c > NegLimit) begin
            c = NegLimit;
            sat = 1'b1;
          end
          comp[k] = 48'((128'd0 - c) & Mask48);
        end else begin
          if (c > PosLimit) begin
            c = PosLimit;
            sat = 1'b1;
          end
          comp[k] = c[47:0];
        end
      end
    end
    f.fx = comp[0];
    f.fy = comp[1];
    f.fz = comp[2];
    f.apply = newton_q | p.local_j;
    f.sat = sat;
    return f;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegKe: ke_q = val;
      RegLaw: law_q = val[0];
      RegNewton: newton_q = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [31:0] ke, input logic law, input logic newton);
    write_reg(RegKe, ke);
    write_reg(RegLaw, {31'd0, law});
    write_reg(RegNewton, {31'd0, newton});
  endtask

  // one transaction: hold start until the block takes it
  task automatic send_pair(input pair_t p, input bit typed, input force_t f, input bit gaps);
    int unsigned n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_delta_x = p.dx;
    in_delta_y = p.dy;
    in_delta_z = p.dz;
    in_radius_i = p.rad_i;
    in_radius_j = p.rad_j;
    in_plain_mass_i = p.pm_i;
    in_outer_mass_i = p.om_i;
    in_is_eps_i = p.eps_i;
    in_plain_mass_j = p.pm_j;
    in_outer_mass_j = p.om_j;
    in_is_eps_j = p.eps_j;
    in_partner_local = p.local_j;
    do @(posedge clk); while (busy);
    pending_forces.push_back(typed ? f : pair_force(p));
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    logic [31:0] rs, tgt, a, b, c;
    p.pm_i = $urandom;
    p.om_i = $urandom;
    p.pm_j = $urandom;
    p.om_j = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      p.pm_i = p.pm_i >> $urandom_range(8, 24);
      p.om_i = p.om_i >> $urandom_range(8, 24);
      p.pm_j = p.pm_j >> $urandom_range(8, 24);
      p.om_j = p.om_j >> $urandom_range(8, 24);
    end
    p.eps_i = $urandom_range(0, 1);
    p.eps_j = $urandom_range(0, 1);
    p.local_j = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 7) begin
      // pair inside or near the acting shell
      p.rad_i = $urandom_range(0, 32'h0004_0000) << $urandom_range(0, 8);
      p.rad_j = $urandom_range(0, 32'h0004_0000) << $urandom_range(0, 8);
      rs = p.rad_i + p.rad_j;
      if (rs == 0) rs = 1;
      if (rs > 32'h2000_0000) rs = 32'h2000_0000;
      tgt = rs + $urandom_range(0, rs + rs / 8);
      a = tgt;
      b = $urandom_range(0, tgt / 3);
      c = $urandom_range(0, tgt / 3);
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      if ($urandom_range(0, 1)) c = -c;
      case ($urandom_range(0, 2))
        0: begin p.dx = a; p.dy = b; p.dz = c; end
        1: begin p.dx = b; p.dy = a; p.dz = c; end
        default: begin p.dx = c; p.dy = b; p.dz = a; end
      endcase
    end else begin
      p.dx = $urandom;
      p.dy = $urandom;
      p.dz = $urandom;
      p.rad_i = $urandom;
      p.rad_j = $urandom;
      if ($urandom_range(0, 1)) begin
        p.rad_i = p.rad_i >> 16;
        p.rad_j = p.rad_j >> 16;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    force_t e;
    if (rst_n && out_valid) begin
      if (pending_forces.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        e = pending_forces.pop_front();
        if (out_force_x !== e.fx) begin
          $error("force_x expected %h actual %h", e.fx, out_force_x);
          err_cnt++;
        end
        if (out_force_y !== e.fy) begin
          $error("force_y expected %h actual %h", e.fy, out_force_y);
          err_cnt++;
        end
        if (out_force_z !== e.fz) begin
          $error("force_z expected %h actual %h", e.fz, out_force_z);
          err_cnt++;
        end
        if (out_apply_to_partner !== e.apply) begin
          $error("apply_to_partner expected %b actual %b", e.apply, out_apply_to_partner);
          err_cnt++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, out_saturated);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_forces.size() != 0) @(posedge clk);
  endtask

  initial begin
    row_t rows[$];
    row_t rw;
    pair_t base;
    force_t zf;
    logic [31:0] ke_set[5];
    logic law_set[5], newton_set[5];

    rst_n = 1'b0;
    start = 1'b0;
    in_delta_x = '0; in_delta_y = '0; in_delta_z = '0;
    in_radius_i = '0; in_radius_j = '0;
    in_plain_mass_i = '0; in_outer_mass_i = '0; in_is_eps_i = 1'b0;
    in_plain_mass_j = '0; in_outer_mass_j = '0; in_is_eps_j = 1'b0;
    in_partner_local = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ke_q = 32'd65536;
    law_q = LawLinear;
    newton_q = 1'b1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    base = '{dx: 32'd0, dy: 32'd0, dz: 32'd0, rad_i: 32'h0001_0000, rad_j: 32'h0001_0000,
             pm_i: 32'h0001_0000, om_i: 32'h0002_0000, pm_j: 32'h0003_0000,
             om_j: 32'h0004_0000, eps_i: 1'b0, eps_j: 1'b0, local_j: 1'b0};
    zf = '{fx: '0, fy: '0, fz: '0, apply: 1'b1, sat: 1'b0};

    // zero distance
    rw.p = base; rw.typed = 1; rw.f = zf; rows.push_back(rw);
    // overlapping spheres: no force
    rw.p = base; rw.p.dx = 32'h0001_0000; rw.p.rad_i = '1; rw.p.rad_j = '1;
    rw.typed = 1; rw.f = zf; rows.push_back(rw);
    // most negative delta, no mass
    rw.p = base; rw.p.dx = 32'h8000_0000; rw.p.rad_i = 0; rw.p.rad_j = 0;
    rw.p.om_i = 0; rw.p.om_j = 0; rw.typed = 1; rw.f = zf; rows.push_back(rw);
    rw.typed = 0;
    rw.p = base; rw.p.dx = 32'h0003_0000; rows.push_back(rw);
    rw.p = base; rw.p.dx = 32'hFFFD_0000; rw.p.dy = 32'h0000_8000; rows.push_back(rw);
    rw.p = base; rw.p.dz = 32'h0002_8000; rw.p.eps_i = 1; rw.p.local_j = 1; rows.push_back(rw);
    rw.p = base; rw.p.dy = 32'hFFFC_8000; rw.p.eps_j = 1; rows.push_back(rw);
    rw.p = base; rw.p.dx = 32'h0002_0000; rw.p.dy = 32'h0002_0000; rw.p.dz = 32'h0002_0000;
    rows.push_back(rw);
    // heavy masses and large deltas
    rw.p = base; rw.p.dx = 32'h7FFF_FFFF; rw.p.dy = 32'h4000_0000;
    rw.p.rad_i = 32'h4000_0000; rw.p.rad_j = 32'h3000_0000;
    rw.p.om_i = '1; rw.p.om_j = '1; rw.p.pm_i = '1; rw.p.pm_j = '1; rows.push_back(rw);
    rw.p.dx = 32'h8000_0000; rw.p.dy = 32'hC000_0000; rw.p.dz = 32'h8000_0001;
    rw.p.eps_i = 1; rw.p.eps_j = 1; rows.push_back(rw);
    rw.p = base; rw.p.dx = 32'h7FFF_FFFF; rw.p.dy = 32'h7FFF_FFFF; rw.p.dz = 32'h7FFF_FFFF;
    rw.p.rad_i = '1; rw.p.rad_j = '1; rows.push_back(rw);
    rw.p = base; rw.p.dx = 32'h0000_0001; rw.p.rad_i = 0; rw.p.rad_j = 0; rows.push_back(rw);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].f, 1'b0);
    @(negedge clk);
    start = 1'b0;
    wait_drained();

    ke_set = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h0004_0000, 32'd65536};
    law_set = '{LawInvSq, LawLinear, LawInvSq, LawInvSq, LawLinear};
    newton_set = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    ke_set[3] = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      set_config(ke_set[ph], law_set[ph], newton_set[ph]);
      for (int n = 0; n < RandPerPhase; n++)
        send_pair(random_pair(), 1'b0, zf, !(ph == 4 && n > RandPerPhase / 2));
      @(negedge clk);
      start = 1'b0;
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0 && pending_forces.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
